// ----- rtl/cds_pkg.sv -----
// Package for the calendar date stepper: types, codes and date helpers.
// No dependencies.
package cds_pkg;

    localparam logic [0:0] CMD_SET = 1'b0;
    localparam logic [0:0] CMD_ADD = 1'b1;

    localparam logic [2:0] UNIT_DAY0  = 3'd0;
    localparam logic [2:0] UNIT_DAY1  = 3'd1;
    localparam logic [2:0] UNIT_WEEK  = 3'd2;
    localparam logic [2:0] UNIT_MONTH = 3'd3;
    localparam logic [2:0] UNIT_YEAR  = 3'd4;
    localparam logic [2:0] UNIT_BAD5  = 3'd5;
    localparam logic [2:0] UNIT_BAD6  = 3'd6;
    localparam logic [2:0] UNIT_BAD7  = 3'd7;

    localparam logic [1:0] ERR_OK    = 2'd0;
    localparam logic [1:0] ERR_DATE  = 2'd1;
    localparam logic [1:0] ERR_UNIT  = 2'd2;
    localparam logic [1:0] ERR_RANGE = 2'd3;

    typedef struct packed {
        logic [0:0]  command;
        logic [2:0]  unit;
        logic [15:0] amount;
        logic [4:0]  new_day;
        logic [3:0]  new_month;
        logic [13:0] new_year;
    } t_in;

    typedef struct packed {
        logic [4:0]  day;
        logic [3:0]  month;
        logic [13:0] year;
        logic [2:0]  weekday;
        logic [4:0]  month_length;
        logic [1:0]  error;
    } t_out;

    // datapath commands
    typedef struct packed {
        logic load;      // capture item, set up counter
        logic step;      // one iteration
        logic finish;    // commit or drop, compute outputs
    } t_cmd;

    typedef struct packed {
        logic done;      // iteration count exhausted or error found
    } t_sts;

    // y / 100 as (y / 4) / 25, the latter by reciprocal 1311 / 2^15 (exact below 16384)
    function automatic logic [7:0] div100(input logic [13:0] y);
        logic [22:0] p;
        begin
            p      = {11'd0, y[13:2]} * 23'd1311;
            div100 = p[22:15];
        end
    endfunction

    function automatic logic is_leap(input logic [13:0] y);
        logic [7:0] q;
        logic       c100;
        logic       c400;
        begin
            q    = div100(y);
            c100 = (y[1:0] == 2'b00) && (y[13:2] == {4'd0, q} * 12'd25);
            c400 = c100 && (q[1:0] == 2'b00);
            is_leap = ((y[1:0] == 2'b00) && !c100) || c400;
        end
    endfunction

    function automatic logic [4:0] month_len(input logic [3:0] m, input logic [13:0] y);
        begin
            if (m == 4'd2)
                month_len = is_leap(y) ? 5'd29 : 5'd28;
            else if (m == 4'd4 || m == 4'd6 || m == 4'd9 || m == 4'd11)
                month_len = 5'd30;
            else
                month_len = 5'd31;
        end
    endfunction

    function automatic logic [2:0] dow_offset(input logic [3:0] m);
        logic [2:0] r;
        begin
            case (m)
                4'd1:    r = 3'd0;
                4'd2:    r = 3'd3;
                4'd3:    r = 3'd2;
                4'd4:    r = 3'd5;
                4'd5:    r = 3'd0;
                4'd6:    r = 3'd3;
                4'd7:    r = 3'd5;
                4'd8:    r = 3'd1;
                4'd9:    r = 3'd4;
                4'd10:   r = 3'd6;
                4'd11:   r = 3'd2;
                4'd12:   r = 3'd4;
                default: r = 3'd0;
            endcase
            dow_offset = r;
        end
    endfunction

endpackage

// ----- rtl/cds_if.sv -----
// Valid/ready channel interface carrying one word of type T.
// No dependencies; the payload type is set by parameter T.
interface cds_if #(parameter type T = logic) ();
    logic valid;
    logic ready;
    T     data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ----- rtl/cds_weekday.sv -----
// Weekday unit: three-stage pipeline of year sums, reciprocal divisions and mod 7 folding.
// Depends on cds_pkg.
module cds_weekday (
    input  logic        i_clk,
    input  logic        i_start,
    input  logic [4:0]  i_day,
    input  logic [3:0]  i_month,
    input  logic [13:0] i_year,
    output logic [2:0]  o_weekday,
    output logic        o_done
);
    logic [13:0] r_yy;
    logic [4:0]  r_d;
    logic [3:0]  r_m;
    logic [16:0] r_sum;
    logic [2:0]  r_wd;
    logic [2:0]  r_vld;
    logic [13:0] n_yy;
    logic [7:0]  w_q;
    logic [5:0]  w_f1;
    logic [3:0]  w_f2;
    logic [2:0]  w_mod;

    assign n_yy = (i_month < 4'd3 && i_year != 14'd0) ? i_year - 14'd1 : i_year;
    assign w_q  = cds_pkg::div100(r_yy);

    // 8 = 1 mod 7: sum octal digits twice, then one conditional subtract
    assign w_f1 = {3'd0, r_sum[2:0]} + {3'd0, r_sum[5:3]} + {3'd0, r_sum[8:6]}
                + {3'd0, r_sum[11:9]} + {3'd0, r_sum[14:12]} + {4'd0, r_sum[16:15]};
    assign w_f2 = {1'b0, w_f1[2:0]} + {1'b0, w_f1[5:3]};
    assign w_mod = (w_f2 >= 4'd7) ? 3'(w_f2 - 4'd7) : w_f2[2:0];

    always_ff @(posedge i_clk) begin
        r_vld <= {r_vld[1:0], i_start};
        r_yy  <= n_yy;
        r_d   <= i_day;
        r_m   <= i_month;
        r_sum <= {3'd0, r_yy} + {5'd0, r_yy[13:2]} - {9'd0, w_q}
               + {11'd0, w_q[7:2]} + {14'd0, cds_pkg::dow_offset(r_m)} + {12'd0, r_d};
        r_wd  <= w_mod;
    end

    assign o_weekday = r_wd;
    assign o_done    = r_vld[2];
endmodule

// ----- rtl/cds_datapath.sv -----
// Datapath: date regs, working copy and one day/month step per commanded cycle.
// Depends on cds_pkg and cds_weekday.
module cds_datapath #(
    parameter int MIN_YEAR = 1900,
    parameter int MAX_YEAR = 9999
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  cds_pkg::t_in   i_item,
    input  cds_pkg::t_cmd  i_cmd,
    output cds_pkg::t_sts  o_sts,
    output cds_pkg::t_out  o_res,
    output logic           o_res_done
);
    localparam logic [13:0] YMIN = 14'(MIN_YEAR);
    localparam logic [13:0] YMAX = 14'(MAX_YEAR);

    logic [4:0]  r_day, r_wday;
    logic [3:0]  r_month, r_wmon;
    logic [13:0] r_year, r_wyear;
    logic [19:0] r_cnt;     // remaining days or months
    logic        r_neg;
    logic        r_mode_mon;
    logic [1:0]  r_err;
    logic [1:0]  r_oerr;
    logic        r_wstart;

    logic [4:0]  w_len;
    logic [4:0]  w_prev_len;
    logic [3:0]  w_prev_m;
    logic [13:0] w_prev_y;
    logic [3:0]  w_next_m;
    logic [13:0] w_next_y;
    logic        w_next_ovf;
    logic [4:0]  w_next_len;
    logic [19:0] w_abs;
    logic [19:0] w_amt7;
    logic signed [16:0] w_ysum;
    logic [13:0] w_ynew;
    logic [4:0]  w_ylen;
    logic [2:0]  w_wd;
    logic        w_wdone;

    assign w_len      = cds_pkg::month_len(r_wmon, r_wyear);
    assign w_prev_m   = (r_wmon == 4'd1) ? 4'd12 : r_wmon - 4'd1;
    assign w_prev_y   = (r_wmon == 4'd1) ? r_wyear - 14'd1 : r_wyear;
    assign w_prev_len = cds_pkg::month_len(w_prev_m, w_prev_y);
    assign w_next_m   = (r_wmon == 4'd12) ? 4'd1 : r_wmon + 4'd1;
    assign w_next_y   = (r_wmon == 4'd12) ? r_wyear + 14'd1 : r_wyear;
    assign w_next_ovf = (r_wmon == 4'd12) && (r_wyear >= YMAX);
    assign w_next_len = cds_pkg::month_len(w_next_m, w_next_y);

    assign w_amt7 = {{4{i_item.amount[15]}}, i_item.amount} * 20'sd7;
    assign w_abs  = (i_item.unit == cds_pkg::UNIT_WEEK)
                  ? (w_amt7[19] ? 20'(-w_amt7) : w_amt7)
                  : (i_item.amount[15] ? 20'(-{{4{i_item.amount[15]}}, i_item.amount})
                                       : {4'd0, i_item.amount});
    assign w_ysum = $signed({3'd0, r_year}) + $signed({i_item.amount[15], i_item.amount});
    assign w_ynew = w_ysum[13:0];
    assign w_ylen = cds_pkg::month_len(r_month, w_ynew);

    assign o_sts.done = (r_cnt == 20'd0) || (r_err != cds_pkg::ERR_OK);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_day    <= 5'd1;
            r_month  <= 4'd1;
            r_year   <= YMIN;
            r_wstart <= 1'b0;
        end else begin
            r_wstart <= i_cmd.finish;
            if (i_cmd.finish && r_err == cds_pkg::ERR_OK) begin
                r_day   <= r_wday;
                r_month <= r_wmon;
                r_year  <= r_wyear;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.finish)
            r_oerr <= r_err;
        if (i_cmd.load) begin
            r_wday     <= r_day;
            r_wmon     <= r_month;
            r_wyear    <= r_year;
            r_cnt      <= 20'd0;
            r_neg      <= 1'b0;
            r_mode_mon <= 1'b0;
            r_err      <= cds_pkg::ERR_OK;
            if (i_item.command == cds_pkg::CMD_SET) begin
                if (i_item.new_month < 4'd1 || i_item.new_month > 4'd12
                    || i_item.new_year < YMIN || i_item.new_year > YMAX
                    || i_item.new_day < 5'd1
                    || i_item.new_day > cds_pkg::month_len(i_item.new_month, i_item.new_year))
                    r_err <= cds_pkg::ERR_DATE;
                else begin
                    r_wday  <= i_item.new_day;
                    r_wmon  <= i_item.new_month;
                    r_wyear <= i_item.new_year;
                end
            end else begin
                unique case (i_item.unit)
                    cds_pkg::UNIT_DAY0, cds_pkg::UNIT_DAY1, cds_pkg::UNIT_WEEK: begin
                        r_cnt <= w_abs;
                        r_neg <= (i_item.unit == cds_pkg::UNIT_WEEK) ? w_amt7[19]
                                                                     : i_item.amount[15];
                    end
                    cds_pkg::UNIT_MONTH: begin
                        r_cnt      <= w_abs;
                        r_neg      <= i_item.amount[15];
                        r_mode_mon <= 1'b1;
                    end
                    cds_pkg::UNIT_YEAR: begin
                        if (w_ysum < $signed({3'd0, YMIN}) || w_ysum > $signed({3'd0, YMAX}))
                            r_err <= cds_pkg::ERR_RANGE;
                        else begin
                            r_wyear <= w_ynew;
                            if (r_day > w_ylen)
                                r_wday <= w_ylen;
                        end
                    end
                    default: r_err <= cds_pkg::ERR_UNIT;
                endcase
            end
        end else if (i_cmd.step && r_cnt != 20'd0 && r_err == cds_pkg::ERR_OK) begin
            if (r_mode_mon) begin
                r_cnt <= r_cnt - 20'd1;
                if (r_neg) begin
                    if (w_prev_y < YMIN) r_err <= cds_pkg::ERR_RANGE;
                    r_wmon  <= w_prev_m;
                    r_wyear <= w_prev_y;
                    if (r_wday > w_prev_len) r_wday <= w_prev_len;
                end else begin
                    if (w_next_ovf) r_err <= cds_pkg::ERR_RANGE;
                    r_wmon  <= w_next_m;
                    r_wyear <= w_next_y;
                    if (r_wday > w_next_len) r_wday <= w_next_len;
                end
            end else if (r_neg) begin
                if ({15'd0, r_wday} > r_cnt) begin
                    r_wday <= r_wday - 5'(r_cnt);
                    r_cnt  <= 20'd0;
                end else begin
                    r_cnt   <= r_cnt - {15'd0, r_wday};
                    r_wmon  <= w_prev_m;
                    r_wyear <= w_prev_y;
                    r_wday  <= w_prev_len;
                    if (w_prev_y < YMIN) r_err <= cds_pkg::ERR_RANGE;
                end
            end else begin
                if ({15'd0, w_len - r_wday} >= r_cnt) begin
                    r_wday <= r_wday + 5'(r_cnt);
                    r_cnt  <= 20'd0;
                end else begin
                    r_cnt   <= r_cnt - {15'd0, w_len - r_wday} - 20'd1;
                    r_wday  <= 5'd1;
                    r_wmon  <= w_next_m;
                    r_wyear <= w_next_y;
                    if (w_next_ovf) r_err <= cds_pkg::ERR_RANGE;
                end
            end
        end
    end

    cds_weekday u_wd (
        .i_clk     (i_clk),
        .i_start   (r_wstart),
        .i_day     (r_day),
        .i_month   (r_month),
        .i_year    (r_year),
        .o_weekday (w_wd),
        .o_done    (w_wdone)
    );

    assign o_res.day          = r_day;
    assign o_res.month        = r_month;
    assign o_res.year         = r_year;
    assign o_res.weekday      = w_wd;
    assign o_res.month_length = cds_pkg::month_len(r_month, r_year);
    assign o_res.error        = r_oerr;
    assign o_res_done         = w_wdone;
endmodule

// ----- rtl/cds_ctrl.sv -----
// Controller: sequences load, iteration, commit and result handshake.
// Depends on cds_pkg.
module cds_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    output logic          o_out_valid,
    input  logic          i_out_ready,
    input  cds_pkg::t_sts i_sts,
    input  logic          i_res_done,
    output cds_pkg::t_cmd o_cmd
);
    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_RUN  = 3'd1;
    localparam logic [2:0] S_FIN  = 3'd2;
    localparam logic [2:0] S_WAIT = 3'd3;
    localparam logic [2:0] S_OUT  = 3'd4;

    logic [2:0] r_state, n_state;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                o_cmd.load = i_in_valid;
                if (i_in_valid) n_state = S_RUN;
            end
            S_RUN: begin
                o_cmd.step = 1'b1;
                if (i_sts.done) n_state = S_FIN;
            end
            S_FIN: begin
                o_cmd.finish = 1'b1;
                n_state = S_WAIT;
            end
            S_WAIT: if (i_res_done) n_state = S_OUT;
            S_OUT:  if (i_out_ready) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= S_IDLE;
        else          r_state <= n_state;
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = (r_state == S_OUT);
endmodule

// ----- rtl/calendar_date_stepper.sv -----
// Calendar date stepper top level: controller, datapath, assertions.
// A set, a year step or a zero amount needs no iteration; a nonzero day or week step
// iterates month by month to the target, a month step one month at a time.
// One word at a time: no new input is taken until the result has been accepted.
// Reset (synchronous, active low) sets the date to 1/1 of MIN_YEAR.
// Depends on cds_pkg, cds_if, cds_ctrl, cds_datapath.
module calendar_date_stepper #(
    parameter int MIN_YEAR = 1900,
    parameter int MAX_YEAR = 9999
) (
    input  logic i_clk,
    input  logic i_rst_n,
    cds_if.sink   i_in,
    cds_if.source o_out
);
    cds_pkg::t_cmd w_cmd;
    cds_pkg::t_sts w_sts;
    cds_pkg::t_out w_res;
    logic          w_res_done;

    cds_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .o_in_ready  (i_in.ready),
        .o_out_valid (o_out.valid),
        .i_out_ready (o_out.ready),
        .i_sts       (w_sts),
        .i_res_done  (w_res_done),
        .o_cmd       (w_cmd)
    );

    cds_datapath #(.MIN_YEAR(MIN_YEAR), .MAX_YEAR(MAX_YEAR)) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_item     (i_in.data),
        .i_cmd      (w_cmd),
        .o_sts      (w_sts),
        .o_res      (w_res),
        .o_res_done (w_res_done)
    );

    assign o_out.data = w_res;

    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_in.ready && o_out.valid)) else $error("input taken while result pending");
    a_load_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({w_cmd.load, w_cmd.step, w_cmd.finish})) else $error("command overlap");
    a_month_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid |-> (o_out.data.month >= 4'd1 && o_out.data.month <= 4'd12))
        else $error("month out of range");
endmodule
